### rtl/ecpr_pkg.sv
// shared types and constants for the enhanced clock page replacer
// no dependencies
`default_nettype none

package ecpr_pkg;

  localparam int unsigned MODE_W            = 2;
  localparam int unsigned FRAME_IDX_W       = 6;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned NUM_FRAMES_DEF    = 64;
  localparam int unsigned PAGE_NUM_BITS_DEF = 20;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_EVICT  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_RESIDENT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_HAND,
    ST_LNK_RD,
    ST_LNK_WR,
    ST_ACC_WR,
    ST_EV_RD,
    ST_EV_CHK
  } state_e;

endpackage

`default_nettype wire

### rtl/ecpr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ecpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/enhanced_clock_page_replacer.sv
// enhanced second-chance clock page replacer, top level; uses ecpr_pkg and ecpr_ram
// access reads the entry and sets its marks; insert checks it, reads the hand entry,
// writes it and relinks; evict clears marks up to an unmarked victim and unlinks it
// one item at a time, every step bound by the registered read of the frame entry ram
// after reset a clearing pass that writes every frame entry to zero holds busy high
// results are shown for one cycle on done_o; the receiver cannot stall
`default_nettype none

module enhanced_clock_page_replacer #(
  parameter int unsigned NUM_FRAMES    = ecpr_pkg::NUM_FRAMES_DEF,
  parameter int unsigned PAGE_NUM_BITS = ecpr_pkg::PAGE_NUM_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [ecpr_pkg::MODE_W-1:0]        mode_i,
  input  wire logic [ecpr_pkg::FRAME_IDX_W-1:0]   frame_index_i,
  input  wire logic [PAGE_NUM_BITS-1:0]           page_number_i,
  input  wire logic                               is_write_i,
  output logic                                    done_o,
  output logic      [ecpr_pkg::STATUS_W-1:0]      status_o,
  output logic      [ecpr_pkg::FRAME_IDX_W-1:0]   victim_frame_o,
  output logic      [PAGE_NUM_BITS-1:0]           victim_page_o
);

  import ecpr_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned PW = PAGE_NUM_BITS;

  typedef struct packed {
    logic          res;
    logic          acc;
    logic          dirty;
    logic [PW-1:0] page;
    logic [FW-1:0] prev;
    logic [FW-1:0] next;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  state_e  state_q, state_d;
  logic [FW-1:0] cur_q, cur_d;
  logic [PW-1:0] page_q, page_d;
  logic          wr_q, wr_d;
  logic          evict_q, evict_d;
  logic [FW-1:0] hand_q, hand_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] lnk_a_q, lnk_a_d;
  logic [FW-1:0] lnk_b_q, lnk_b_d;
  logic [FW-1:0] lnk_v1_q, lnk_v1_d;
  logic [FW-1:0] lnk_v2_q, lnk_v2_d;
  logic          step_q, step_d;
  logic [FW-1:0] clr_q, clr_d;

  logic                   done_q;
  status_e                status_q;
  logic [FRAME_IDX_W-1:0] vframe_q;
  logic [PW-1:0]          vpage_q;

  logic                   res_valid;
  status_e                res_status;
  logic [FRAME_IDX_W-1:0] res_frame;
  logic [PW-1:0]          res_page;

  logic          ram_we;
  logic [FW-1:0] ram_waddr;
  logic [FW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_e;
  entry_t        wr_e;

  logic          idx_ok;
  logic [FW-1:0] idx;

  assign rd_e   = entry_t'(ram_rdata);
  assign idx_ok = 32'(frame_index_i) < NUM_FRAMES;
  assign idx    = FW'(frame_index_i);

  ecpr_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_FRAMES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_e),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    page_d     = page_q;
    wr_d       = wr_q;
    evict_d    = evict_q;
    hand_d     = hand_q;
    count_d    = count_q;
    lnk_a_d    = lnk_a_q;
    lnk_b_d    = lnk_b_q;
    lnk_v1_d   = lnk_v1_q;
    lnk_v2_d   = lnk_v2_q;
    step_d     = step_q;
    clr_d      = clr_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q;
    ram_raddr  = cur_q;
    wr_e       = rd_e;
    res_valid  = 1'b0;
    res_status = STATUS_OK;
    res_frame  = '0;
    res_page   = '0;
    busy       = (state_q != ST_IDLE);

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        wr_e      = '0;
        if (clr_q == FW'(NUM_FRAMES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + FW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          cur_d     = idx;
          page_d    = page_number_i;
          wr_d      = is_write_i;
          evict_d   = 1'b0;
          ram_raddr = idx;
          case (mode_i)
            MODE_INSERT: begin
              if (idx_ok) begin
                state_d = ST_INS_CHK;
              end else begin
                res_valid = 1'b1;
              end
            end
            MODE_ACCESS: begin
              if (idx_ok) begin
                state_d = ST_ACC_WR;
              end else begin
                res_valid = 1'b1;
              end
            end
            MODE_EVICT: begin
              if (count_q == '0) begin
                res_valid  = 1'b1;
                res_status = STATUS_EMPTY;
              end else begin
                evict_d   = 1'b1;
                cur_d     = hand_q;
                ram_raddr = hand_q;
                state_d   = ST_EV_CHK;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      ST_INS_CHK: begin
        if (rd_e.res) begin
          res_valid  = 1'b1;
          res_status = STATUS_RESIDENT;
          state_d    = ST_IDLE;
        end else if (count_q == '0) begin
          wr_e.res   = 1'b1;
          wr_e.acc   = 1'b0;
          wr_e.dirty = 1'b0;
          wr_e.page  = page_q;
          wr_e.prev  = cur_q;
          wr_e.next  = cur_q;
          ram_we     = 1'b1;
          hand_d     = cur_q;
          count_d    = count_q + CW'(1);
          res_valid  = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          ram_raddr = hand_q;
          state_d   = ST_INS_HAND;
        end
      end

      ST_INS_HAND: begin
        wr_e.res   = 1'b1;
        wr_e.acc   = 1'b0;
        wr_e.dirty = 1'b0;
        wr_e.page  = page_q;
        wr_e.prev  = rd_e.prev;
        wr_e.next  = hand_q;
        ram_we     = 1'b1;
        count_d    = count_q + CW'(1);
        lnk_a_d    = rd_e.prev;
        lnk_v1_d   = cur_q;
        lnk_b_d    = hand_q;
        lnk_v2_d   = cur_q;
        step_d     = 1'b0;
        state_d    = ST_LNK_RD;
      end

      ST_LNK_RD: begin
        ram_raddr = step_q ? lnk_b_q : lnk_a_q;
        state_d   = ST_LNK_WR;
      end

      ST_LNK_WR: begin
        ram_we = 1'b1;
        if (!step_q) begin
          wr_e.next = lnk_v1_q;
          ram_waddr = lnk_a_q;
          step_d    = 1'b1;
          state_d   = ST_LNK_RD;
        end else begin
          wr_e.prev = lnk_v2_q;
          ram_waddr = lnk_b_q;
          res_valid = 1'b1;
          if (evict_q) begin
            res_frame = FRAME_IDX_W'(cur_q);
            res_page  = page_q;
          end
          state_d = ST_IDLE;
        end
      end

      ST_ACC_WR: begin
        if (rd_e.res) begin
          wr_e.acc   = 1'b1;
          wr_e.dirty = rd_e.dirty | wr_q;
          ram_we     = 1'b1;
        end
        res_valid = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_EV_RD: begin
        state_d = ST_EV_CHK;
      end

      ST_EV_CHK: begin
        ram_we = 1'b1;
        if (rd_e.acc || rd_e.dirty) begin
          wr_e.acc   = 1'b0;
          wr_e.dirty = rd_e.acc & rd_e.dirty;
          cur_d      = rd_e.next;
          state_d    = ST_EV_RD;
        end else begin
          wr_e.res   = 1'b0;
          wr_e.acc   = 1'b0;
          wr_e.dirty = 1'b0;
          page_d     = rd_e.page;
          count_d    = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            hand_d    = '0;
            res_valid = 1'b1;
            res_frame = FRAME_IDX_W'(cur_q);
            res_page  = rd_e.page;
            state_d   = ST_IDLE;
          end else begin
            hand_d   = rd_e.next;
            lnk_a_d  = rd_e.prev;
            lnk_v1_d = rd_e.next;
            lnk_b_d  = rd_e.next;
            lnk_v2_d = rd_e.prev;
            step_d   = 1'b0;
            state_d  = ST_LNK_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      hand_q  <= '0;
      count_q <= '0;
      step_q  <= 1'b0;
      evict_q <= 1'b0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
      count_q <= count_d;
      step_q  <= step_d;
      evict_q <= evict_d;
      clr_q   <= clr_d;
      done_q  <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    page_q   <= page_d;
    wr_q     <= wr_d;
    lnk_a_q  <= lnk_a_d;
    lnk_b_q  <= lnk_b_d;
    lnk_v1_q <= lnk_v1_d;
    lnk_v2_q <= lnk_v2_d;
    if (res_valid) begin
      status_q <= res_status;
      vframe_q <= res_frame;
      vpage_q  <= res_page;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign victim_frame_o = vframe_q;
  assign victim_page_o  = vpage_q;

endmodule

`default_nettype wire

### sim/ecpr_ring_checker.sv
// ring checker for the enhanced clock page replacer: watches the item and result ports,
// predicts every result from its own copy of the ring and compares field by field
// depends on ecpr_pkg
module ecpr_ring_checker #(
  parameter int unsigned NUM_FRAMES    = ecpr_pkg::NUM_FRAMES_DEF,
  parameter int unsigned PAGE_NUM_BITS = ecpr_pkg::PAGE_NUM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [ecpr_pkg::MODE_W-1:0]        mode_i,
  input  logic [ecpr_pkg::FRAME_IDX_W-1:0]   frame_index_i,
  input  logic [PAGE_NUM_BITS-1:0]           page_number_i,
  input  logic                               is_write_i,
  input  logic                               done_i,
  input  logic [ecpr_pkg::STATUS_W-1:0]      status_i,
  input  logic [ecpr_pkg::FRAME_IDX_W-1:0]   victim_frame_i,
  input  logic [PAGE_NUM_BITS-1:0]           victim_page_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 compared_o,
  output int                                 max_sweep_o,
  output logic [NUM_FRAMES-1:0]              resident_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ecpr_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic [FRAME_IDX_W-1:0]   frame;
    logic [PAGE_NUM_BITS-1:0] page;
  } victim_result_t;

  logic [FRAME_IDX_W-1:0]   next_of [NUM_FRAMES];
  logic [FRAME_IDX_W-1:0]   prev_of [NUM_FRAMES];
  logic [PAGE_NUM_BITS-1:0] page_of [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]    accessed;
  logic [NUM_FRAMES-1:0]    dirty;
  logic [NUM_FRAMES-1:0]    resident;
  logic [FRAME_IDX_W-1:0]   hand;
  int unsigned              ring_len;

  victim_result_t expected_results [$];
  int mismatch_count = 0;
  int compared_count = 0;
  int longest_sweep  = 0;

  assign fail_count_o = mismatch_count;
  assign compared_o   = compared_count;
  assign max_sweep_o  = longest_sweep;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void link_before_hand(input int unsigned f);
    int unsigned h, p;
    if (ring_len == 0) begin
      next_of[f] = FRAME_IDX_W'(f);
      prev_of[f] = FRAME_IDX_W'(f);
      hand       = FRAME_IDX_W'(f);
    end else begin
      h = hand;
      p = prev_of[h];
      next_of[f] = FRAME_IDX_W'(h);
      prev_of[f] = FRAME_IDX_W'(p);
      next_of[p] = FRAME_IDX_W'(f);
      prev_of[h] = FRAME_IDX_W'(f);
    end
    ring_len++;
  endfunction

  function automatic victim_result_t apply_to_ring(input logic [MODE_W-1:0] m,
                                                   input logic [FRAME_IDX_W-1:0] idx,
                                                   input logic [PAGE_NUM_BITS-1:0] pg,
                                                   input logic wr);
    victim_result_t r;
    int unsigned cur, sweep, nx, pv;
    r.status = STATUS_OK;
    r.frame  = '0;
    r.page   = '0;
    if (m == MODE_EVICT) begin
      if (ring_len == 0) begin
        r.status = STATUS_EMPTY;
        return r;
      end
      cur   = hand;
      sweep = 0;
      while ((accessed[cur] || dirty[cur]) && sweep <= 3 * NUM_FRAMES) begin
        if (!accessed[cur]) dirty[cur] = 1'b0;
        accessed[cur] = 1'b0;
        cur = next_of[cur];
        sweep++;
      end
      if (sweep > longest_sweep) longest_sweep = sweep;
      r.frame = FRAME_IDX_W'(cur);
      r.page  = page_of[cur];
      nx = next_of[cur];
      pv = prev_of[cur];
      ring_len--;
      if (ring_len == 0) begin
        hand = '0;
      end else begin
        next_of[pv] = FRAME_IDX_W'(nx);
        prev_of[nx] = FRAME_IDX_W'(pv);
        hand        = FRAME_IDX_W'(nx);
      end
      resident[cur] = 1'b0;
      accessed[cur] = 1'b0;
      dirty[cur]    = 1'b0;
      return r;
    end
    if (idx >= NUM_FRAMES) return r;
    if (m == MODE_INSERT) begin
      if (resident[idx]) begin
        r.status = STATUS_RESIDENT;
        return r;
      end
      page_of[idx]  = pg;
      accessed[idx] = 1'b0;
      dirty[idx]    = 1'b0;
      resident[idx] = 1'b1;
      link_before_hand(idx);
    end else if (m == MODE_ACCESS && resident[idx]) begin
      accessed[idx] = 1'b1;
      if (wr) dirty[idx] = 1'b1;
    end
    return r;
  endfunction

  task automatic check_result();
    victim_result_t w;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with no item outstanding, status %0d", status_i));
      return;
    end
    w = expected_results.pop_front();
    compared_count++;
    if (status_i !== w.status)
      report_mismatch($sformatf("status %0d, want %0d", status_i, w.status));
    if (victim_frame_i !== w.frame)
      report_mismatch($sformatf("victim_frame %0d, want %0d", victim_frame_i, w.frame));
    if (victim_page_i !== w.page)
      report_mismatch($sformatf("victim_page %h, want %h", victim_page_i, w.page));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        next_of[i] = '0;
        prev_of[i] = '0;
        page_of[i] = '0;
      end
      accessed = '0;
      dirty    = '0;
      resident = '0;
      hand     = '0;
      ring_len = 0;
      expected_results.delete();
      pending_o  <= 0;
      resident_o <= '0;
    end else begin
      if (done_i) check_result();
      if (start_i && !busy_i)
        expected_results.push_back(apply_to_ring(mode_i, frame_index_i, page_number_i,
                                                 is_write_i));
      pending_o  <= expected_results.size();
      resident_o <= resident;
    end
  end

endmodule

### sim/tb_enhanced_clock_page_replacer.sv
// testbench top for the enhanced clock page replacer: drives directed and random items
// and gives the verdict; depends on ecpr_pkg, the block and ecpr_ring_checker
module tb_enhanced_clock_page_replacer;
  timeunit 1ns;
  timeprecision 1ps;
  import ecpr_pkg::*;

  localparam int unsigned FRAMES       = NUM_FRAMES_DEF;
  localparam int unsigned PAGE_W       = PAGE_NUM_BITS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic [PAGE_W-1:0] PAGE_ALL_ONES = '1;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   start         = 1'b0;
  logic [MODE_W-1:0]      mode          = MODE_INSERT;
  logic [FRAME_IDX_W-1:0] frame_index   = '0;
  logic [PAGE_W-1:0]      page_number   = '0;
  logic                   is_write      = 1'b0;
  logic                   busy;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [FRAME_IDX_W-1:0] victim_frame;
  logic [PAGE_W-1:0]      victim_page;

  int                fail_count;
  int                pending;
  int                compared;
  int                max_sweep;
  logic [FRAMES-1:0] resident;
  int                mode_count [4] = '{default: 0};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  enhanced_clock_page_replacer #(
    .NUM_FRAMES   (FRAMES),
    .PAGE_NUM_BITS(PAGE_W)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode),
    .frame_index_i (frame_index),
    .page_number_i (page_number),
    .is_write_i    (is_write),
    .done_o        (done),
    .status_o      (status),
    .victim_frame_o(victim_frame),
    .victim_page_o (victim_page)
  );

  ecpr_ring_checker #(
    .NUM_FRAMES   (FRAMES),
    .PAGE_NUM_BITS(PAGE_W)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .mode_i        (mode),
    .frame_index_i (frame_index),
    .page_number_i (page_number),
    .is_write_i    (is_write),
    .done_i        (done),
    .status_i      (status),
    .victim_frame_i(victim_frame),
    .victim_page_i (victim_page),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .compared_o    (compared),
    .max_sweep_o   (max_sweep),
    .resident_o    (resident)
  );

  task automatic issue(input logic [MODE_W-1:0] m, input logic [FRAME_IDX_W-1:0] idx,
                       input logic [PAGE_W-1:0] pg, input logic wr, input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    frame_index <= idx;
    page_number <= pg;
    is_write    <= wr;
    @(posedge clk);
    while (busy) @(posedge clk);
    mode_count[m]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [FRAME_IDX_W-1:0] pick_frame(input logic want_resident);
    int unsigned base, k;
    base = $urandom_range(0, FRAMES - 1);
    for (k = 0; k < FRAMES; k++)
      if (resident[(base + k) % FRAMES] == want_resident)
        return FRAME_IDX_W'((base + k) % FRAMES);
    return FRAME_IDX_W'(base);
  endfunction

  task automatic random_item(input int unsigned fill, input int idle_pct);
    int unsigned ring, roll, ins_w, ev_w;
    logic [FRAME_IDX_W-1:0] idx;
    logic [PAGE_W-1:0] pg;
    logic wr;
    ring = $countones(resident);
    roll = $urandom_range(0, 99);
    pg   = PAGE_W'($urandom);
    wr   = 1'($urandom);
    idx  = FRAME_IDX_W'($urandom);
    if (roll < 6) begin
      issue(MODE_W'($urandom_range(0, 3)), idx, pg, wr, idle_pct);
      return;
    end
    ins_w = (ring < fill) ? 45 : 15;
    ev_w  = (ring < fill) ? 15 : 35;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) begin
      if ($urandom_range(0, 9) != 0) idx = pick_frame(1'b0);
      issue(MODE_INSERT, idx, pg, wr, idle_pct);
    end else if (roll < ins_w + ev_w) begin
      issue(MODE_EVICT, idx, pg, wr, idle_pct);
    end else begin
      if ($urandom_range(0, 9) != 0) idx = pick_frame(1'b1);
      issue(MODE_ACCESS, idx, pg, wr, idle_pct);
    end
  endtask

  initial begin
    #6_000_000;
    $display("tb_enhanced_clock_page_replacer NOT OK");
    $finish;
  end

  initial begin
    int unsigned fill_levels [5] = '{2, 8, 24, 48, 64};
    int idle_for_phase [3] = '{15, 60, 0};
    int unsigned fill;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring, marks, duplicates, unused mode, last-frame eviction
    issue(MODE_EVICT, 6'd0, '0, 1'b0, 15);
    issue(MODE_ACCESS, 6'd10, '0, 1'b1, 15);
    issue(MODE_INSERT, 6'd0, '0, 1'b0, 15);
    issue(MODE_INSERT, 6'd63, PAGE_ALL_ONES, 1'b1, 15);
    issue(MODE_INSERT, 6'd0, 20'h00005, 1'b0, 15);
    issue(MODE_ACCESS, 6'd63, '0, 1'b1, 15);
    issue(MODE_ACCESS, 6'd0, PAGE_ALL_ONES, 1'b0, 15);
    issue(MODE_UNUSED, 6'd63, PAGE_ALL_ONES, 1'b1, 15);
    issue(MODE_INSERT, 6'd42, 20'h5A5A5, 1'b0, 15);
    issue(MODE_EVICT, 6'd0, '0, 1'b0, 15);
    issue(MODE_EVICT, 6'd63, PAGE_ALL_ONES, 1'b1, 15);
    issue(MODE_EVICT, 6'd0, '0, 1'b0, 15);
    issue(MODE_EVICT, 6'd0, '0, 1'b0, 15);
    // four frames, each accessed and dirty: the sweep needs two full rounds
    for (int f = 1; f <= 4; f++) issue(MODE_INSERT, FRAME_IDX_W'(f), PAGE_W'(f * 20'h3C3C3), 1'b1, 0);
    for (int f = 1; f <= 4; f++) issue(MODE_ACCESS, FRAME_IDX_W'(f), '0, 1'b1, 0);
    issue(MODE_EVICT, 6'd21, 20'hAAAAA, 1'b1, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      fill = fill_levels[$urandom_range(0, 4)];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 35 == 0) fill = fill_levels[$urandom_range(0, 4)];
        random_item(fill, idle_for_phase[ph]);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d accesses, %0d evicts, %0d unused-mode items",
             mode_count[MODE_INSERT], mode_count[MODE_ACCESS], mode_count[MODE_EVICT],
             mode_count[MODE_UNUSED]);
    $display("%0d results compared, longest sweep past marked frames %0d", compared, max_sweep);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_enhanced_clock_page_replacer OK");
    end else begin
      $display("tb_enhanced_clock_page_replacer NOT OK");
    end
    $finish;
  end

endmodule
